// File: hdl/becu_pkg.sv
// Shared types and constants of the block extent coalescer.
package becu_pkg;

  localparam int FW  = 48;
  localparam int LW  = 49;
  localparam int UW  = 17;
  localparam int BBW = 17;
  localparam int BOW = 49;
  localparam int NW  = 66;
  localparam int CTRW = 7;

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_BYTE   = 3'd1;
  localparam logic [2:0] MODE_BRANGE = 3'd2;
  localparam logic [2:0] MODE_KBLOCK = 3'd3;
  localparam logic [2:0] MODE_KRANGE = 3'd4;
  localparam logic [2:0] MODE_END    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SESS  = 2'd1;
  localparam logic [1:0] ST_REVERSED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_BASE_OFFSET = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_POST, S_MUL, S_DIVL, S_DIV, S_SAVE, S_SPAN,
    S_SI_RD, S_SI_CK, S_SJ_CK, S_SJ_RD, S_DEC, S_INS_RD, S_INS_WR,
    S_MC_RD, S_MC_WR, S_E_RD, S_E_OUT
  } state_t;

  typedef enum logic {RS_P, RS_PM1} rsel_t;
  typedef enum logic [1:0] {WA_P, WA_D, WA_I} wsel_t;
  typedef enum logic [1:0] {WD_NEW, WD_MERGE, WD_COPY} wdsel_t;

  typedef struct packed {
    logic       cap;
    logic       set_open;
    logic       clr_open;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_sub;
    logic       set_st;
    logic [1:0] st;
    logic       ar_load;
    logic       ar_phase;
    logic       mul_step;
    logic       div_load;
    logic       div_step;
    logic       save;
    logic       p_clr;
    logic       p_inc;
    logic       p_dec;
    logic       p_cnt;
    logic       p_j;
    logic       d_i1;
    logic       d_inc;
    logic       set_i;
    logic       set_j;
    logic       set_last;
    logic       rd;
    rsel_t      rsel;
    logic       we;
    wsel_t      wa;
    wdsel_t     wd;
    logic       post;
    logic       post_run;
    logic       post_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       open;
    logic       rev;
    logic       skip;
    logic       ctr_done;
    logic       phase;
    logic       span_empty;
    logic       p_eq_cnt;
    logic       p_eq_i;
    logic       below;
    logic       joins;
    logic       i_eq_j;
    logic       full;
    logic       p_last;
    logic       cnt_zero;
    logic       out_free;
  } sts_t;

endpackage

// File: hdl/block_extent_coalescer_unit.sv
// Top level of the block extent coalescer.
// The unit keeps a sorted table of up to MAX_RUNS maximal block runs claimed in a session and
// works on one item at a time. Start, end without a session, reversed ranges and unused modes
// post only a status. An add that claims blocks runs a shift-add multiplier and a restoring
// divider, loaded first, once for each end of its span, then walks the run table one entry
// at a time as it passes, merges or moves entries. An end emits its runs one at a time. One
// result item can wait in the output register while the unit goes on.
module block_extent_coalescer_unit import becu_pkg::*; #(
  parameter int MAX_RUNS  = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [BOW-1:0] cfg_data,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // first_value, last_value, unit_bytes
  input  logic [119:0]   s_axis_tdata,
  // mode
  input  logic [2:0]     s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // status, run_start, run_length
  output logic [103:0]   m_axis_tdata,
  // run_valid
  output logic           m_axis_tuser,
  output logic           m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  becu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  becu_dpath #(
    .MAX_RUNS  (MAX_RUNS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser),
    .out_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/becu_ctrl.sv
// Controller state machine of the block extent coalescer.
module becu_ctrl import becu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rsel = RS_P;
    cmd.wa = WA_P;
    cmd.wd = WD_COPY;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.set_st = 1'b1;
        cmd.st = ST_OK;
        state_next = S_POST;
        if (sts.mode == MODE_START) begin
          cmd.cnt_clr = 1'b1;
          cmd.set_open = 1'b1;
        end else if (sts.mode == MODE_END) begin
          if (!sts.open) begin
            cmd.st = ST_NO_SESS;
          end else begin
            cmd.clr_open = 1'b1;
            if (!sts.cnt_zero) begin
              cmd.p_clr = 1'b1;
              state_next = S_E_RD;
            end
          end
        end else if (sts.mode inside {MODE_BYTE, MODE_BRANGE, MODE_KBLOCK, MODE_KRANGE}) begin
          if (!sts.open) begin
            cmd.st = ST_NO_SESS;
          end else if (sts.rev) begin
            cmd.st = ST_REVERSED;
          end else if (!sts.skip) begin
            cmd.ar_load = 1'b1;
            cmd.ar_phase = 1'b0;
            state_next = S_MUL;
          end
        end
      end
      S_POST: begin
        if (sts.out_free) begin
          cmd.post = 1'b1;
          cmd.post_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (sts.ctr_done) begin
          state_next = S_DIVL;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.ctr_done) begin
          state_next = S_SAVE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (!sts.phase) begin
          cmd.ar_load = 1'b1;
          cmd.ar_phase = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        if (sts.span_empty) begin
          state_next = S_POST;
        end else begin
          cmd.p_clr = 1'b1;
          state_next = S_SI_RD;
        end
      end
      S_SI_RD: begin
        if (sts.p_eq_cnt) begin
          cmd.set_i = 1'b1;
          cmd.set_j = 1'b1;
          state_next = S_DEC;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_SI_CK;
        end
      end
      S_SI_CK: begin
        if (sts.below) begin
          cmd.p_inc = 1'b1;
          state_next = S_SI_RD;
        end else begin
          cmd.set_i = 1'b1;
          state_next = S_SJ_CK;
        end
      end
      S_SJ_CK: begin
        if (sts.joins) begin
          cmd.set_last = 1'b1;
          cmd.p_inc = 1'b1;
          state_next = S_SJ_RD;
        end else begin
          cmd.set_j = 1'b1;
          state_next = S_DEC;
        end
      end
      S_SJ_RD: begin
        if (sts.p_eq_cnt) begin
          cmd.set_j = 1'b1;
          state_next = S_DEC;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_SJ_CK;
        end
      end
      S_DEC: begin
        if (sts.i_eq_j) begin
          if (sts.full) begin
            cmd.set_st = 1'b1;
            cmd.st = ST_FULL;
            state_next = S_POST;
          end else begin
            cmd.p_cnt = 1'b1;
            state_next = S_INS_RD;
          end
        end else begin
          cmd.we = 1'b1;
          cmd.wa = WA_I;
          cmd.wd = WD_MERGE;
          cmd.d_i1 = 1'b1;
          cmd.p_j = 1'b1;
          state_next = S_MC_RD;
        end
      end
      S_INS_RD: begin
        if (sts.p_eq_i) begin
          cmd.we = 1'b1;
          cmd.wa = WA_I;
          cmd.wd = WD_NEW;
          cmd.cnt_inc = 1'b1;
          state_next = S_POST;
        end else begin
          cmd.rd = 1'b1;
          cmd.rsel = RS_PM1;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.we = 1'b1;
        cmd.wa = WA_P;
        cmd.wd = WD_COPY;
        cmd.p_dec = 1'b1;
        state_next = S_INS_RD;
      end
      S_MC_RD: begin
        if (sts.p_eq_cnt) begin
          cmd.cnt_sub = 1'b1;
          state_next = S_POST;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_MC_WR;
        end
      end
      S_MC_WR: begin
        cmd.we = 1'b1;
        cmd.wa = WA_D;
        cmd.wd = WD_COPY;
        cmd.p_inc = 1'b1;
        cmd.d_inc = 1'b1;
        state_next = S_MC_RD;
      end
      S_E_RD: begin
        cmd.rd = 1'b1;
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        if (sts.out_free) begin
          cmd.post = 1'b1;
          cmd.post_run = 1'b1;
          cmd.post_last = sts.p_last;
          if (sts.p_last) begin
            cmd.cnt_clr = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.p_inc = 1'b1;
            state_next = S_E_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/becu_dpath.sv
// Datapath of the block extent coalescer: registers, multiplier, divider, run table, output.
module becu_dpath import becu_pkg::*; #(
  parameter int MAX_RUNS  = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [BOW-1:0]   cfg_data,
  input  logic [119:0]     in_tdata,
  input  logic [2:0]       in_tuser,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [103:0]     out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  localparam int AW = ADDR_BITS;
  localparam int CW = AW + 1;
  localparam int IW = $clog2(MAX_RUNS);
  localparam int PW = $clog2(MAX_RUNS + 1);
  localparam logic [NW:0] LIMIT_Q = {{(NW - AW){1'b0}}, 1'b1, {AW{1'b0}}};

  logic [BBW-1:0] bb_r;
  logic [BOW-1:0] base_r;
  logic [2:0]     mode_r;
  logic [FW-1:0]  a_r, b_r;
  logic [UW-1:0]  unit_r;
  logic           open_r;
  logic [1:0]     st_r;

  logic [FW-1:0]  m2;
  logic [UW-1:0]  u;
  logic [BBW-1:0] bs;

  logic           phase;
  logic [NW-1:0]  acc, mcand, dv;
  logic [UW-1:0]  ush;
  logic [BBW-1:0] rem;
  logic [CTRW-1:0] ctr;
  logic [BBW:0]   trial;
  logic [NW:0]    s_big;
  logic           s_bad;
  logic [AW-1:0]  s_r, e_r;

  logic [AW-1:0]  tf [MAX_RUNS];
  logic [CW-1:0]  tc [MAX_RUNS];
  logic [AW-1:0]  rd_first;
  logic [CW-1:0]  rd_count;
  logic [PW-1:0]  p, d, i_idx, j_idx, cnt, raddr, waddr;
  logic [AW-1:0]  first_i, last_end, ns, ne, wfirst;
  logic [CW-1:0]  wcount, lsum;
  logic [AW+1:0]  rend;
  logic [63:0]    ext_first, ext_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bb_r <= BBW'(512);
      base_r <= '1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BLOCK_BYTES) begin
        bb_r <= cfg_data[BBW-1:0];
      end else begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= in_tuser;
      a_r <= in_tdata[47:0];
      b_r <= in_tdata[95:48];
      unit_r <= in_tdata[112:96];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_r <= 1'b0;
    end else if (cmd.set_open) begin
      open_r <= 1'b1;
    end else if (cmd.clr_open) begin
      open_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
  end

  assign m2 = (mode_r == MODE_BRANGE || mode_r == MODE_KRANGE) ? b_r : a_r;
  assign u = (mode_r == MODE_KBLOCK || mode_r == MODE_KRANGE) ? unit_r : UW'(1);
  assign bs = (bb_r == '0) ? BBW'(1) : bb_r;
  assign trial = {rem, dv[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.ar_load) begin
      phase <= cmd.ar_phase;
      if (cmd.ar_phase) begin
        acc <= NW'(u) + NW'(base_r[FW-1:0]) - NW'(1);
        mcand <= NW'(m2);
      end else begin
        acc <= NW'(base_r[FW-1:0]);
        mcand <= NW'(a_r);
      end
      ush <= u;
      ctr <= CTRW'(UW);
    end else if (cmd.mul_step) begin
      if (ush[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[NW-2:0], 1'b0};
      ush <= {1'b0, ush[UW-1:1]};
      ctr <= ctr - CTRW'(1);
    end else if (cmd.div_load) begin
      dv <= acc;
      rem <= '0;
      ctr <= CTRW'(NW);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, bs}) begin
        rem <= BBW'(trial - {1'b0, bs});
        dv <= {dv[NW-2:0], 1'b1};
      end else begin
        rem <= trial[BBW-1:0];
        dv <= {dv[NW-2:0], 1'b0};
      end
      ctr <= ctr - CTRW'(1);
    end
  end

  assign s_big = {1'b0, dv} + (NW + 1)'(rem != '0);

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      if (!phase) begin
        s_bad <= s_big >= LIMIT_Q;
        s_r <= s_big[AW-1:0];
      end else if ({1'b0, dv} >= LIMIT_Q) begin
        e_r <= '1;
      end else begin
        e_r <= dv[AW-1:0];
      end
    end
  end

  assign raddr = (cmd.rsel == RS_PM1) ? p - PW'(1) : p;

  always_comb begin
    case (cmd.wa)
      WA_P:    waddr = p;
      WA_D:    waddr = d;
      default: waddr = i_idx;
    endcase
  end

  assign ns = (first_i < s_r) ? first_i : s_r;
  assign ne = (last_end > e_r) ? last_end : e_r;

  always_comb begin
    case (cmd.wd)
      WD_NEW: begin
        wfirst = s_r;
        wcount = CW'(e_r) - CW'(s_r) + CW'(1);
      end
      WD_MERGE: begin
        wfirst = ns;
        wcount = CW'(ne) - CW'(ns) + CW'(1);
      end
      default: begin
        wfirst = rd_first;
        wcount = rd_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      tf[waddr[IW-1:0]] <= wfirst;
      tc[waddr[IW-1:0]] <= wcount;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_first <= tf[raddr[IW-1:0]];
      rd_count <= tc[raddr[IW-1:0]];
    end
  end

  assign lsum = CW'(rd_first) + rd_count - CW'(1);
  assign rend = (AW + 2)'(rd_first) + (AW + 2)'(rd_count);

  always_ff @(posedge clk) begin
    if (cmd.set_i) begin
      i_idx <= p;
      first_i <= rd_first;
    end
    if (cmd.set_j) begin
      j_idx <= p;
    end
    if (cmd.set_last) begin
      last_end <= lsum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + PW'(1);
    end else if (cmd.cnt_sub) begin
      cnt <= cnt - (j_idx - i_idx - PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_clr) begin
      p <= '0;
    end else if (cmd.p_inc) begin
      p <= p + PW'(1);
    end else if (cmd.p_dec) begin
      p <= p - PW'(1);
    end else if (cmd.p_cnt) begin
      p <= cnt;
    end else if (cmd.p_j) begin
      p <= j_idx;
    end
    if (cmd.d_i1) begin
      d <= i_idx + PW'(1);
    end else if (cmd.d_inc) begin
      d <= d + PW'(1);
    end
  end

  assign ext_first = 64'(rd_first);
  assign ext_count = 64'(rd_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.post) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_tlast <= cmd.post_last;
      out_tuser <= cmd.post_run;
      if (cmd.post_run) begin
        out_tdata <= {5'd0, ext_count[LW-1:0], ext_first[FW-1:0], ST_OK};
      end else begin
        out_tdata <= {102'd0, st_r};
      end
    end
  end

  always_comb begin
    sts.mode = mode_r;
    sts.open = open_r;
    sts.rev = a_r > m2;
    sts.skip = base_r[BOW-1] || (u == '0);
    sts.ctr_done = (ctr == '0);
    sts.phase = phase;
    sts.span_empty = s_bad || (s_r > e_r);
    sts.p_eq_cnt = (p == cnt);
    sts.p_eq_i = (p == i_idx);
    sts.below = rend < (AW + 2)'(s_r);
    sts.joins = CW'(rd_first) <= CW'(e_r) + CW'(1);
    sts.i_eq_j = (i_idx == j_idx);
    sts.full = (cnt == PW'(MAX_RUNS));
    sts.p_last = ((p + PW'(1)) == cnt);
    sts.cnt_zero = (cnt == '0);
    sts.out_free = !out_tvalid || out_tready;
  end

endmodule

// File: hdl/becu_checker.sv
// Port checker of the block extent coalescer and its bind.
module becu_checker import becu_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  a_norun_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("result item without a run is not the last");

  a_norun_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[103:2] == '0)
    else $error("result item without a run carries run fields");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> !m_axis_tuser)
    else $error("error status on an emitted run");

endmodule

bind block_extent_coalescer_unit becu_checker u_becu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
